[design/aef_pkg.sv]
`timescale 1ns / 1ps
package aef_pkg;

	localparam int SEQ_MAX_DEF = 64;
	localparam int CNT_W       = 7;
	localparam int WR_AW       = 6;
	localparam int CLOSE_LEN   = 7;
	localparam int TAB_STOP    = 8;

	localparam logic [1:0] REG_FILTER_ALL    = 2'd0;
	localparam logic [1:0] REG_DISPLAY_WIDTH = 2'd1;
	localparam logic [1:0] REG_EXPAND_TABS   = 2'd2;

	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_M     = 8'h6d;

	typedef enum logic [3:0] {
		M_TEXT, M_ESC, M_CSI, M_OSC_PS, M_OSC_SEMI, M_OSC_BODY, M_OSC_BODY_ESC, M_NF, M_UTF8
	} mode_t;

	typedef enum logic [2:0] {
		K_NONE, K_END, K_BYTE, K_SPACES, K_BUF, K_CLOSE
	} kind_t;

	typedef enum logic {B_IDLE, B_RUN} bstate_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [CNT_W-1:0] cnt;
		logic             last;
		logic             ovf;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [WR_AW-1:0] addr;
		logic [7:0]       data;
	} bufwr_t;

	typedef struct packed {
		logic        filter_all;
		logic [15:0] width;
		logic        expand_tabs;
	} cfg_t;

	// hyperlink close: ESC ] 8 ; ; ESC backslash
	function automatic logic [7:0] close_byte(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = CH_ESC;
			3'd1: r = CH_RBRK;
			3'd2: r = CH_EIGHT;
			3'd3: r = CH_SEMI;
			3'd4: r = CH_SEMI;
			3'd5: r = CH_ESC;
			3'd6: r = CH_BSL;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v != 16'hffff) ? v + 16'd1 : v;
	endfunction

endpackage

[design/aef_queue.sv]
`timescale 1ns / 1ps
module aef_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aef_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output aef_pkg::cmd_t  head
);
	aef_pkg::cmd_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[design/aef_front.sv]
`timescale 1ns / 1ps
module aef_front #(
	parameter int SEQ_MAX = aef_pkg::SEQ_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  aef_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            has_byte,
	input  logic            is_last,
	input  logic            q_full,
	output logic            q_push,
	output aef_pkg::cmd_t   q_cmd,
	output aef_pkg::bufwr_t buf_wr,
	input  logic            buf_done
);
	localparam int LEN_W = $clog2(SEQ_MAX + 1);

	aef_pkg::mode_t   mode_q, mode_n;
	logic [15:0]      col_q, col_n;
	logic             hl_q, hl_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [7:0]       osc_q, osc_n;
	logic [1:0]       utf_q, utf_n;
	logic [1:0]       cs_q, cs_n;
	logic             ovf_q, ovf_n;
	logic             drop_q, drop_n;
	logic             pm_q, pm_n;
	logic             busy_q;

	aef_pkg::kind_t   kind;
	logic [7:0]       data;
	logic [aef_pkg::CNT_W-1:0] cnt;
	logic             add_en, add_rst, do_nf, do_text, do_body;
	logic [7:0]       osc_v;
	logic             a_drop, a_pm;
	logic [LEN_W-1:0] a_len;
	logic [LEN_W-1:0] base_len;
	logic             base_drop, base_pm;
	logic [15:0]      c1, tab_end;
	logic [16:0]      tab_up;
	logic             acc;
	logic [7:0]       b;

	assign b        = in_byte;
	assign in_ready = !q_full && !busy_q;
	assign acc      = in_valid && in_ready;

	// effect of storing the byte onto the current sequence
	always_comb begin
		a_drop = drop_q || (len_q >= LEN_W'(SEQ_MAX));
		a_len  = a_drop ? len_q : len_q + LEN_W'(1);
		a_pm   = pm_q && (len_q < LEN_W'(aef_pkg::CLOSE_LEN))
			&& (b == aef_pkg::close_byte(len_q[2:0]));
	end

	// tab stop arithmetic
	always_comb begin
		c1      = aef_pkg::sat_inc(col_q);
		tab_up  = ({1'b0, c1} + 17'(aef_pkg::TAB_STOP - 1)) & ~17'(aef_pkg::TAB_STOP - 1);
		tab_end = (tab_up > {1'b0, cfg.width}) ? cfg.width : tab_up[15:0];
	end

	always_comb begin
		mode_n  = mode_q;
		col_n   = col_q;
		hl_n    = hl_q;
		len_n   = len_q;
		osc_n   = osc_q;
		utf_n   = utf_q;
		cs_n    = cs_q;
		ovf_n   = ovf_q;
		drop_n  = drop_q;
		pm_n    = pm_q;
		kind    = aef_pkg::K_NONE;
		data    = b;
		cnt     = aef_pkg::CNT_W'(1);
		add_en  = 1'b0;
		add_rst = 1'b0;
		do_nf   = 1'b0;
		do_text = 1'b0;
		do_body = 1'b0;
		osc_v   = osc_q;
		buf_wr  = '0;

		case (mode_q)
			aef_pkg::M_ESC: begin
				if (b == aef_pkg::CH_LBRK) begin
					add_en = 1'b1;
					mode_n = aef_pkg::M_CSI;
				end else if (b == aef_pkg::CH_RBRK) begin
					add_en = 1'b1;
					osc_n  = 8'h00;
					mode_n = aef_pkg::M_OSC_PS;
				end else begin
					mode_n = aef_pkg::M_NF;
					do_nf  = 1'b1;
				end
			end
			aef_pkg::M_CSI: begin
				if (b inside {[8'h20:8'h3f]}) begin
					add_en = 1'b1;
				end else begin
					mode_n = aef_pkg::M_TEXT;
					if (b inside {[8'h40:8'h7e]}) begin
						add_en = 1'b1;
						// colour sequence goes out whole
						if (!cfg.filter_all && b == aef_pkg::CH_M && !a_drop) begin
							kind = aef_pkg::K_BUF;
							cnt  = aef_pkg::CNT_W'(a_len);
						end
					end else begin
						do_text = 1'b1;
					end
				end
			end
			aef_pkg::M_OSC_PS: begin
				if (b inside {[8'h30:8'h3f]}) begin
					add_en = 1'b1;
					osc_n  = b;
					mode_n = aef_pkg::M_OSC_SEMI;
				end else begin
					osc_v   = 8'h00;
					osc_n   = 8'h00;
					do_body = 1'b1;
				end
			end
			aef_pkg::M_OSC_SEMI: begin
				osc_v   = (b != aef_pkg::CH_SEMI) ? 8'h00 : osc_q;
				osc_n   = osc_v;
				do_body = 1'b1;
			end
			aef_pkg::M_OSC_BODY: begin
				do_body = 1'b1;
			end
			aef_pkg::M_OSC_BODY_ESC: begin
				if (b == aef_pkg::CH_BSL) begin
					add_en = 1'b1;
					if (!cfg.filter_all && osc_q == aef_pkg::CH_EIGHT && !a_drop) begin
						hl_n = !(a_len == LEN_W'(aef_pkg::CLOSE_LEN) && a_pm);
						kind = aef_pkg::K_BUF;
						cnt  = aef_pkg::CNT_W'(a_len);
					end
					mode_n = aef_pkg::M_TEXT;
				end else begin
					do_body = 1'b1;
				end
			end
			aef_pkg::M_NF: begin
				do_nf = 1'b1;
			end
			aef_pkg::M_UTF8: begin
				if (b[7:6] == 2'b10 && utf_q != 2'd0) begin
					kind  = aef_pkg::K_BYTE;
					utf_n = utf_q - 2'd1;
					if (utf_q == 2'd1) begin
						mode_n = aef_pkg::M_TEXT;
					end
				end else begin
					utf_n   = 2'd0;
					mode_n  = aef_pkg::M_TEXT;
					do_text = 1'b1;
				end
			end
			default: begin
				mode_n  = aef_pkg::M_TEXT;
				do_text = 1'b1;
			end
		endcase

		// osc body byte, ended by BEL or ESC backslash
		if (do_body) begin
			add_en = 1'b1;
			if (b == aef_pkg::CH_BEL) begin
				if (!cfg.filter_all && osc_v == aef_pkg::CH_EIGHT && !a_drop) begin
					hl_n = !(len_q == LEN_W'(aef_pkg::CLOSE_LEN - 2) && pm_q);
					kind = aef_pkg::K_BUF;
					cnt  = aef_pkg::CNT_W'(a_len);
				end
				mode_n = aef_pkg::M_TEXT;
			end else if (b == aef_pkg::CH_ESC) begin
				mode_n = aef_pkg::M_OSC_BODY_ESC;
			end else begin
				mode_n = aef_pkg::M_OSC_BODY;
			end
		end

		// nF escape: intermediates eaten, final ends it
		if (do_nf) begin
			if (b == aef_pkg::CH_ESC || b == aef_pkg::CH_TAB || b[7]) begin
				mode_n  = aef_pkg::M_TEXT;
				do_text = 1'b1;
			end else if (b >= aef_pkg::CH_DIG0) begin
				mode_n = aef_pkg::M_TEXT;
			end else if (b >= aef_pkg::CH_SPACE || b == aef_pkg::CH_CR || b == aef_pkg::CH_BEL) begin
				mode_n = aef_pkg::M_NF;
			end else begin
				kind  = aef_pkg::K_BYTE;
				col_n = c1;
				if (c1 >= cfg.width) begin
					mode_n = aef_pkg::M_TEXT;
				end
			end
		end

		if (do_text) begin
			if (col_q >= cfg.width) begin
				// past the limit: only watch for the next hyperlink opener
				if (hl_q) begin
					if (b == aef_pkg::CH_ESC) begin
						cs_n = 2'd1;
					end else if (cs_q == 2'd1 && b == aef_pkg::CH_RBRK) begin
						cs_n = 2'd2;
					end else if (cs_q == 2'd2 && b == aef_pkg::CH_EIGHT) begin
						cs_n = 2'd3;
					end else if (cs_q == 2'd3 && b == aef_pkg::CH_SEMI) begin
						kind = aef_pkg::K_CLOSE;
						cnt  = aef_pkg::CNT_W'(aef_pkg::CLOSE_LEN);
						hl_n = 1'b0;
						cs_n = 2'd0;
					end else begin
						cs_n = 2'd0;
					end
				end
			end else if (b == aef_pkg::CH_ESC) begin
				add_en  = 1'b1;
				add_rst = 1'b1;
				mode_n  = aef_pkg::M_ESC;
			end else if (b == aef_pkg::CH_TAB && cfg.expand_tabs) begin
				kind = aef_pkg::K_SPACES;
				if (c1 >= cfg.width) begin
					col_n = c1;
				end else begin
					col_n = tab_end;
					cnt   = aef_pkg::CNT_W'(tab_end - c1) + aef_pkg::CNT_W'(1);
				end
			end else if (b == aef_pkg::CH_CR || b == aef_pkg::CH_BEL) begin
				kind = aef_pkg::K_NONE;
			end else begin
				col_n = c1;
				kind  = aef_pkg::K_BYTE;
				if (b[7:5] == 3'b110) begin
					utf_n = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					utf_n = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					utf_n = 2'd3;
				end else begin
					utf_n = 2'd0;
				end
				if (utf_n != 2'd0) begin
					mode_n = aef_pkg::M_UTF8;
				end
			end
		end

		// sequence buffer store
		base_len  = add_rst ? '0 : len_q;
		base_drop = add_rst ? 1'b0 : drop_q;
		base_pm   = add_rst ? 1'b1 : pm_q;
		if (add_en) begin
			len_n  = base_len;
			drop_n = base_drop;
			pm_n   = base_pm;
			if (!base_drop) begin
				if (base_len < LEN_W'(SEQ_MAX)) begin
					buf_wr.en   = acc && has_byte;
					buf_wr.addr = aef_pkg::WR_AW'(base_len);
					buf_wr.data = b;
					len_n = base_len + LEN_W'(1);
					pm_n  = base_pm && (base_len < LEN_W'(aef_pkg::CLOSE_LEN))
						&& (b == aef_pkg::close_byte(base_len[2:0]));
				end else begin
					drop_n = 1'b1;
					ovf_n  = 1'b1;
				end
			end
		end

		if (!has_byte) begin
			kind = aef_pkg::K_NONE;
		end
		q_cmd.kind = (is_last && kind == aef_pkg::K_NONE) ? aef_pkg::K_END : kind;
		q_cmd.data = data;
		q_cmd.cnt  = cnt;
		q_cmd.last = is_last;
		q_cmd.ovf  = has_byte ? ovf_n : ovf_q;
		q_push     = acc && (q_cmd.kind != aef_pkg::K_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= aef_pkg::M_TEXT;
			col_q  <= '0;
			hl_q   <= 1'b0;
			len_q  <= '0;
			osc_q  <= '0;
			utf_q  <= '0;
			cs_q   <= '0;
			ovf_q  <= 1'b0;
			drop_q <= 1'b0;
			pm_q   <= 1'b1;
			busy_q <= 1'b0;
		end else begin
			if (acc && is_last) begin
				mode_q <= aef_pkg::M_TEXT;
				col_q  <= '0;
				hl_q   <= 1'b0;
				len_q  <= '0;
				osc_q  <= '0;
				utf_q  <= '0;
				cs_q   <= '0;
				ovf_q  <= 1'b0;
				drop_q <= 1'b0;
				pm_q   <= 1'b1;
			end else if (acc && has_byte) begin
				mode_q <= mode_n;
				col_q  <= col_n;
				hl_q   <= hl_n;
				len_q  <= len_n;
				osc_q  <= osc_n;
				utf_q  <= utf_n;
				cs_q   <= cs_n;
				ovf_q  <= ovf_n;
				drop_q <= drop_n;
				pm_q   <= pm_n;
			end
			// hold input while the buffer is being replayed
			if (q_push && q_cmd.kind == aef_pkg::K_BUF) begin
				busy_q <= 1'b1;
			end else if (buf_done) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

[design/aef_back.sv]
`timescale 1ns / 1ps
module aef_back #(
	parameter int SEQ_MAX = aef_pkg::SEQ_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  aef_pkg::bufwr_t buf_wr,
	input  logic            q_valid,
	input  aef_pkg::cmd_t   q_head,
	output logic            q_pop,
	output logic            buf_done,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            text_done,
	output logic            seq_overflow
);
	localparam int AW = $clog2(SEQ_MAX);

	logic [7:0]                mem [SEQ_MAX];
	logic [7:0]                rdata_q;
	logic                      rd_ok_q;
	aef_pkg::bstate_t          state_q, state_n;
	aef_pkg::cmd_t             cmd_q;
	logic [aef_pkg::CNT_W-1:0] idx_q;
	logic                      adv, last_el;
	logic [7:0]                cur;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
		end
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	always_comb begin
		last_el = (idx_q == cmd_q.cnt - aef_pkg::CNT_W'(1));
		adv     = (state_q == aef_pkg::B_RUN) && (!out_valid || out_ready)
			&& (cmd_q.kind != aef_pkg::K_BUF || rd_ok_q);
		q_pop   = (state_q == aef_pkg::B_IDLE) && q_valid;
		buf_done = adv && last_el && (cmd_q.kind == aef_pkg::K_BUF);
		case (cmd_q.kind)
			aef_pkg::K_BYTE:   cur = cmd_q.data;
			aef_pkg::K_SPACES: cur = aef_pkg::CH_SPACE;
			aef_pkg::K_BUF:    cur = rdata_q;
			aef_pkg::K_CLOSE:  cur = aef_pkg::close_byte(idx_q[2:0]);
			default:           cur = 8'h00;
		endcase
		state_n = state_q;
		case (state_q)
			aef_pkg::B_IDLE: begin
				if (q_valid) begin
					state_n = aef_pkg::B_RUN;
				end
			end
			aef_pkg::B_RUN: begin
				if (adv && last_el) begin
					state_n = aef_pkg::B_IDLE;
				end
			end
			default: state_n = aef_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aef_pkg::B_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_ok_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_ok_q <= (state_q == aef_pkg::B_RUN) && !adv;
			if (q_pop) begin
				idx_q <= '0;
			end else if (adv) begin
				idx_q <= idx_q + aef_pkg::CNT_W'(1);
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (adv) begin
			out_byte     <= cur;
			byte_valid   <= (cmd_q.kind != aef_pkg::K_END);
			run_last     <= last_el;
			text_done    <= last_el && cmd_q.last;
			seq_overflow <= cmd_q.ovf;
		end
	end
endmodule

[design/ansi_escape_filter_core.sv]
`timescale 1ns / 1ps
// path: a result passes the command queue, the back end's command register and its output
// register; a replayed buffered sequence also waits on the registered buffer read
// throughput: silent transactions go in one per cycle while the queue has room and no replay
// is pending; the back end passes through idle between commands, each replayed buffer byte waits
// for its buffer read, and input holds off while a buffer replay is queued
// reset: arst_n clears parser state, queue, back end and output valid; registers take defaults
module ansi_escape_filter_core #(
	parameter int SEQ_MAX = aef_pkg::SEQ_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	// input transaction
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        has_byte,
	input  logic        is_last,
	// result transaction
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        text_done,
	output logic        seq_overflow
);
	aef_pkg::cfg_t    cfg_q;
	aef_pkg::cmd_t    push_cmd, head;
	aef_pkg::bufwr_t  buf_wr;
	logic             q_full, q_push, q_pop, q_valid, buf_done;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_all  <= 1'b0;
			cfg_q.width       <= 16'd80;
			cfg_q.expand_tabs <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				aef_pkg::REG_FILTER_ALL:    cfg_q.filter_all  <= cfg_wdata[0];
				aef_pkg::REG_DISPLAY_WIDTH: cfg_q.width       <= cfg_wdata;
				aef_pkg::REG_EXPAND_TABS:   cfg_q.expand_tabs <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// front end: parses each byte and issues at most one output command
	aef_front #(.SEQ_MAX(SEQ_MAX)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.has_byte (has_byte),
		.is_last  (is_last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.buf_wr   (buf_wr),
		.buf_done (buf_done)
	);

	// two-entry command queue decouples parsing from emission
	aef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head)
	);

	// back end: expands commands into output bytes, holds the sequence buffer
	aef_back #(.SEQ_MAX(SEQ_MAX)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.buf_wr       (buf_wr),
		.q_valid      (q_valid),
		.q_head       (head),
		.q_pop        (q_pop),
		.buf_done     (buf_done),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.text_done    (text_done),
		.seq_overflow (seq_overflow)
	);
endmodule

[design/aef_checker.sv]
`timescale 1ns / 1ps
module aef_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       text_done
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result dropped or changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("string end without item end");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'h00 && text_done)
		else $error("end marker malformed");
endmodule

bind ansi_escape_filter_core aef_checker u_aef_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.run_last   (run_last),
	.text_done  (text_done)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

	// result fields as the block reports them
	typedef struct packed {
		logic [7:0] ob;
		logic       bv;
		logic       rl;
		logic       td;
		logic       so;
	} text_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = aef_pkg::REG_FILTER_ALL;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        has_byte = 1'b0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        text_done;
	logic        seq_overflow;

	ansi_escape_filter_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_byte(in_byte), .has_byte(has_byte), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .byte_valid(byte_valid), .run_last(run_last),
		.text_done(text_done), .seq_overflow(seq_overflow)
	);

	always #1 clk = ~clk;

	// expected output text, oldest first
	text_res_t filtered_q[$];
	text_res_t step_q[$];
	int        errors = 0;
	int        items_sent = 0;
	int        bytes_seen = 0;
	int        strings_sent = 0;
	bit        no_idle = 1'b0;

	// shadow of the configuration registers
	logic        sh_filter_all = 1'b0;
	logic [15:0] sh_width = 16'd80;
	logic        sh_tabs = 1'b1;

	// shadow of the parser
	aef_pkg::mode_t pmode;
	logic [15:0] col;
	logic        link_open;
	logic [7:0]  seq_buf[64];
	int          seq_len;
	logic [7:0]  osc_param;
	int          utf_left;
	int          scan_step;
	logic        ovf_seen;
	logic        seq_drop;

	localparam logic [7:0] LINK_CLOSE[7] = '{8'h1b, 8'h5d, 8'h38, 8'h3b, 8'h3b, 8'h1b, 8'h5c};

	function automatic void clear_parser();
		pmode = aef_pkg::M_TEXT;
		col = 16'd0;
		link_open = 1'b0;
		seq_len = 0;
		osc_param = 8'd0;
		utf_left = 0;
		scan_step = 0;
		ovf_seen = 1'b0;
		seq_drop = 1'b0;
	endfunction

	function automatic void emit(logic [7:0] b);
		if (step_q.size() < 64)
			step_q.push_back('{ob: b, bv: 1'b1, rl: 1'b0, td: 1'b0, so: 1'b0});
	endfunction

	function automatic void bump();
		if (col != 16'hffff)
			col = col + 16'd1;
	endfunction

	function automatic void seq_add(logic [7:0] b);
		if (!seq_drop) begin
			if (seq_len < 64) begin
				seq_buf[seq_len] = b;
				seq_len++;
			end else begin
				seq_drop = 1'b1;
				ovf_seen = 1'b1;
			end
		end
	endfunction

	function automatic void seq_replay();
		for (int k = 0; k < seq_len; k++)
			emit(seq_buf[k]);
	endfunction

	function automatic bit seq_closes_link();
		bit ok;
		ok = 1'b0;
		if (seq_len == 6 && seq_buf[5] == aef_pkg::CH_BEL) begin
			ok = 1'b1;
			for (int k = 0; k < 5; k++)
				if (seq_buf[k] != LINK_CLOSE[k]) ok = 1'b0;
		end else if (seq_len == 7) begin
			ok = 1'b1;
			for (int k = 0; k < 7; k++)
				if (seq_buf[k] != LINK_CLOSE[k]) ok = 1'b0;
		end
		return ok;
	endfunction

	// past the width: look for the next ESC ] 8 ; while a link is open
	function automatic void scan_for_link(logic [7:0] c);
		if (link_open) begin
			if (c == aef_pkg::CH_ESC) scan_step = 1;
			else if (scan_step == 1 && c == aef_pkg::CH_RBRK) scan_step = 2;
			else if (scan_step == 2 && c == aef_pkg::CH_EIGHT) scan_step = 3;
			else if (scan_step == 3 && c == aef_pkg::CH_SEMI) begin
				for (int k = 0; k < 7; k++) emit(LINK_CLOSE[k]);
				link_open = 1'b0;
				scan_step = 0;
			end else scan_step = 0;
		end
	endfunction

	function automatic void text_char(logic [7:0] b);
		if (col >= sh_width) begin
			scan_for_link(b);
		end else if (b == aef_pkg::CH_ESC) begin
			seq_len = 0;
			seq_drop = 1'b0;
			seq_add(b);
			pmode = aef_pkg::M_ESC;
		end else if (b == aef_pkg::CH_TAB && sh_tabs) begin
			emit(aef_pkg::CH_SPACE);
			bump();
			while (col < sh_width && col[2:0] != 3'd0) begin
				emit(aef_pkg::CH_SPACE);
				bump();
			end
		end else if (b != aef_pkg::CH_CR && b != aef_pkg::CH_BEL) begin
			bump();
			emit(b);
			if (b[7:5] == 3'b110) utf_left = 1;
			else if (b[7:4] == 4'b1110) utf_left = 2;
			else if (b[7:3] == 5'b11110) utf_left = 3;
			else utf_left = 0;
			if (utf_left != 0) pmode = aef_pkg::M_UTF8;
		end
	endfunction

	function automatic void osc_char(logic [7:0] b);
		seq_add(b);
		if (b == aef_pkg::CH_BEL) begin
			if (!sh_filter_all && osc_param == aef_pkg::CH_EIGHT && !seq_drop) begin
				link_open = !seq_closes_link();
				seq_replay();
			end
			pmode = aef_pkg::M_TEXT;
		end else if (b == aef_pkg::CH_ESC) pmode = aef_pkg::M_OSC_BODY_ESC;
		else pmode = aef_pkg::M_OSC_BODY;
	endfunction

	function automatic void parse_char(logic [7:0] b);
		bit fin;
		fin = 1'b0;
		for (int p = 0; p < 4 && !fin; p++) begin
			fin = 1'b1;
			case (pmode)
				aef_pkg::M_ESC: begin
					if (b == aef_pkg::CH_LBRK) begin
						seq_add(b);
						pmode = aef_pkg::M_CSI;
					end else if (b == aef_pkg::CH_RBRK) begin
						seq_add(b);
						osc_param = 8'd0;
						pmode = aef_pkg::M_OSC_PS;
					end else begin
						pmode = aef_pkg::M_NF;
						fin = 1'b0;
					end
				end
				aef_pkg::M_CSI: begin
					if (b >= 8'h20 && b <= 8'h3f) seq_add(b);
					else begin
						pmode = aef_pkg::M_TEXT;
						if (b >= 8'h40 && b <= 8'h7e) begin
							seq_add(b);
							if (!sh_filter_all && b == aef_pkg::CH_M && !seq_drop) seq_replay();
						end else fin = 1'b0;
					end
				end
				aef_pkg::M_OSC_PS: begin
					if (b >= 8'h30 && b <= 8'h3f) begin
						seq_add(b);
						osc_param = b;
						pmode = aef_pkg::M_OSC_SEMI;
					end else begin
						osc_param = 8'd0;
						osc_char(b);
					end
				end
				aef_pkg::M_OSC_SEMI: begin
					if (b != aef_pkg::CH_SEMI) osc_param = 8'd0;
					osc_char(b);
				end
				aef_pkg::M_OSC_BODY: osc_char(b);
				aef_pkg::M_OSC_BODY_ESC: begin
					if (b == aef_pkg::CH_BSL) begin
						seq_add(b);
						if (!sh_filter_all && osc_param == aef_pkg::CH_EIGHT && !seq_drop) begin
							link_open = !seq_closes_link();
							seq_replay();
						end
						pmode = aef_pkg::M_TEXT;
					end else osc_char(b);
				end
				aef_pkg::M_NF: begin
					if (b == aef_pkg::CH_ESC || b == aef_pkg::CH_TAB || b[7]) begin
						pmode = aef_pkg::M_TEXT;
						fin = 1'b0;
					end else if (b >= 8'h30) pmode = aef_pkg::M_TEXT;
					else if (!(b >= 8'h20 || b == aef_pkg::CH_CR || b == aef_pkg::CH_BEL)) begin
						// stray control byte inside an nF escape counts as a column
						emit(b);
						bump();
						if (col >= sh_width) pmode = aef_pkg::M_TEXT;
					end
				end
				aef_pkg::M_UTF8: begin
					if (b[7:6] == 2'b10 && utf_left != 0) begin
						emit(b);
						utf_left--;
						if (utf_left == 0) pmode = aef_pkg::M_TEXT;
					end else begin
						utf_left = 0;
						pmode = aef_pkg::M_TEXT;
						fin = 1'b0;
					end
				end
				default: begin
					pmode = aef_pkg::M_TEXT;
					text_char(b);
				end
			endcase
		end
	endfunction

	// work out the results of one accepted input transaction
	function automatic void predict_filter(logic [7:0] b, logic has, logic last);
		step_q.delete();
		if (has) parse_char(b);
		if (last && step_q.size() == 0)
			step_q.push_back('{ob: 8'd0, bv: 1'b0, rl: 1'b0, td: 1'b0, so: 1'b0});
		foreach (step_q[k]) step_q[k].so = ovf_seen;
		if (step_q.size() > 0) begin
			step_q[step_q.size()-1].rl = 1'b1;
			if (last) step_q[step_q.size()-1].td = 1'b1;
		end
		foreach (step_q[k]) filtered_q.push_back(step_q[k]);
		if (last) clear_parser();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// caller is at a rising edge; returns at the edge where the transaction happened
	task automatic send_item(logic [7:0] b, logic has, logic last);
		int gap;
		bit acc;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		has_byte <= has;
		is_last <= last;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		predict_filter(b, has, last);
		items_sent++;
		if (has) bytes_seen++;
	endtask

	task automatic send_text(logic [7:0] s[$], bit end_marker);
		foreach (s[k])
			send_item(s[k], 1'b1, !end_marker && k == s.size() - 1);
		if (end_marker || s.size() == 0)
			send_item(8'd0, 1'b0, 1'b1);
		strings_sent++;
	endtask

	// block must be idle: wait until all results are out, then let silent items drain
	task automatic settle();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aef_pkg::REG_FILTER_ALL:    sh_filter_all = val[0];
			aef_pkg::REG_DISPLAY_WIDTH: sh_width = val;
			default:                    sh_tabs = val[0];
		endcase
	endtask

	task automatic set_config(logic fa, logic [15:0] w, logic tabs);
		settle();
		write_reg(aef_pkg::REG_FILTER_ALL, {15'd0, fa});
		write_reg(aef_pkg::REG_DISPLAY_WIDTH, w);
		write_reg(aef_pkg::REG_EXPAND_TABS, {15'd0, tabs});
	endtask

	// ---- directed tests ----
	task automatic test_plain_and_controls();
		send_text('{8'h41, 8'h00, 8'hff, aef_pkg::CH_CR, aef_pkg::CH_BEL, aef_pkg::CH_TAB,
			8'h7e}, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_text('{}, 1'b1);
	endtask

	task automatic test_colour_and_links();
		send_text('{aef_pkg::CH_ESC, aef_pkg::CH_LBRK, 8'h31, aef_pkg::CH_M, 8'h61,
			aef_pkg::CH_ESC, aef_pkg::CH_LBRK, 8'h01}, 1'b0);
		send_text('{aef_pkg::CH_ESC, aef_pkg::CH_RBRK, aef_pkg::CH_EIGHT, aef_pkg::CH_SEMI,
			aef_pkg::CH_SEMI, 8'h75, aef_pkg::CH_BEL, 8'h62,
			aef_pkg::CH_ESC, aef_pkg::CH_RBRK, aef_pkg::CH_EIGHT, aef_pkg::CH_SEMI,
			aef_pkg::CH_SEMI, aef_pkg::CH_ESC, aef_pkg::CH_BSL}, 1'b0);
	endtask

	task automatic test_escape_kinds();
		send_text('{aef_pkg::CH_ESC, 8'h28, 8'h01, 8'h42, 8'hc3, 8'ha9, 8'he2, 8'h41,
			aef_pkg::CH_ESC, 8'h25, aef_pkg::CH_TAB}, 1'b1);
	endtask

	task automatic test_truncated_link();
		set_config(1'b0, 16'd3, 1'b1);
		send_text('{aef_pkg::CH_ESC, aef_pkg::CH_RBRK, aef_pkg::CH_EIGHT, aef_pkg::CH_SEMI,
			aef_pkg::CH_SEMI, 8'h75, aef_pkg::CH_BEL, 8'h61, 8'h62, 8'h63, 8'h64,
			aef_pkg::CH_ESC, aef_pkg::CH_RBRK, aef_pkg::CH_EIGHT, aef_pkg::CH_SEMI,
			8'h65}, 1'b0);
	endtask

	task automatic test_long_sequence();
		logic [7:0] s[$];
		s = '{aef_pkg::CH_ESC, aef_pkg::CH_LBRK};
		repeat (70) s.push_back(8'h31);
		s.push_back(aef_pkg::CH_M);
		s.push_back(8'h7a);
		send_text(s, 1'b0);
	endtask

	task automatic test_width_extremes();
		set_config(1'b1, 16'd0, 1'b0);
		send_text('{8'h41, aef_pkg::CH_TAB, aef_pkg::CH_ESC, aef_pkg::CH_LBRK,
			aef_pkg::CH_M}, 1'b0);
		set_config(1'b0, 16'hffff, 1'b0);
		send_text('{aef_pkg::CH_TAB, 8'h41, aef_pkg::CH_TAB}, 1'b0);
	endtask

	// ---- random strings ----
	function automatic void add_segment(ref logic [7:0] s[$]);
		int kind, n;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(1, 6);
			repeat (n) s.push_back(8'($urandom_range(8'h20, 8'h7e)));
		end else if (kind < 45) begin
			s.push_back(aef_pkg::CH_ESC); s.push_back(aef_pkg::CH_LBRK);
			n = $urandom_range(0, 4);
			repeat (n) s.push_back(8'($urandom_range(8'h30, 8'h3f)));
			s.push_back(($urandom_range(0, 2) != 0) ? aef_pkg::CH_M :
				8'($urandom_range(8'h40, 8'h7e)));
		end else if (kind < 58) begin
			s.push_back(aef_pkg::CH_ESC); s.push_back(aef_pkg::CH_RBRK);
			s.push_back(($urandom_range(0, 3) != 0) ? aef_pkg::CH_EIGHT :
				8'($urandom_range(8'h30, 8'h3f)));
			s.push_back(aef_pkg::CH_SEMI); s.push_back(aef_pkg::CH_SEMI);
			n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (n) s.push_back(8'($urandom_range(8'h61, 8'h7a)));
			if ($urandom_range(0, 1) != 0) s.push_back(aef_pkg::CH_BEL);
			else begin
				s.push_back(aef_pkg::CH_ESC); s.push_back(aef_pkg::CH_BSL);
			end
		end else if (kind < 66) begin
			s.push_back(aef_pkg::CH_ESC);
			if ($urandom_range(0, 1) != 0) s.push_back(8'($urandom_range(8'h20, 8'h2f)));
			s.push_back(8'($urandom_range(8'h30, 8'h7f)));
		end else if (kind < 76) begin
			n = $urandom_range(1, 3);
			s.push_back((n == 1) ? 8'($urandom_range(8'hc0, 8'hdf)) :
				(n == 2) ? 8'($urandom_range(8'he0, 8'hef)) :
				8'($urandom_range(8'hf0, 8'hf7)));
			if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
			repeat (n) s.push_back(8'($urandom_range(8'h80, 8'hbf)));
		end else if (kind < 84) begin
			s.push_back(aef_pkg::CH_TAB);
		end else if (kind < 97) begin
			n = $urandom_range(1, 3);
			repeat (n) s.push_back(8'($urandom_range(0, 255)));
		end else begin
			s.push_back(aef_pkg::CH_ESC);
			s.push_back(($urandom_range(0, 1) != 0) ? aef_pkg::CH_LBRK : aef_pkg::CH_RBRK);
			n = $urandom_range(60, 70);
			repeat (n) s.push_back(8'($urandom_range(8'h30, 8'h3a)));
			s.push_back(aef_pkg::CH_M);
		end
	endfunction

	task automatic test_random_text();
		logic [7:0] s[$];
		logic [15:0] widths[7] = '{16'd0, 16'd1, 16'd5, 16'd8, 16'd20, 16'd80, 16'hffff};
		int nseg;
		while (items_sent < 320) begin
			set_config($urandom_range(0, 3) == 0, ($urandom_range(0, 3) == 0) ?
				16'($urandom_range(0, 65535)) : widths[$urandom_range(0, 6)],
				$urandom_range(0, 1) != 0);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (3) begin
				s.delete();
				nseg = $urandom_range(1, 8);
				repeat (nseg) add_segment(s);
				if ($urandom_range(0, 5) == 0) send_item(8'h00, 1'b0, 1'b0);
				send_text(s, $urandom_range(0, 3) == 0);
			end
		end
		no_idle = 1'b0;
	endtask

	// output side: random backpressure
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= no_idle ? 0 : pick_gap();
		end
	end

	// compare each result transaction with the oldest expectation
	always @(negedge clk) begin
		text_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result byte=%h valid=%b last=%b done=%b ovf=%b",
					$time, out_byte, byte_valid, run_last, text_done, seq_overflow);
				errors++;
			end else begin
				want = filtered_q.pop_front();
				if (want !== {out_byte, byte_valid, run_last, text_done, seq_overflow}) begin
					$display("%0t: mismatch expected byte=%h valid=%b last=%b done=%b ovf=%b",
						$time, want.ob, want.bv, want.rl, want.td, want.so);
					$display("%0t:          actual   byte=%h valid=%b last=%b done=%b ovf=%b",
						$time, out_byte, byte_valid, run_last, text_done, seq_overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_and_controls();
		test_colour_and_links();
		test_escape_kinds();
		test_truncated_link();
		test_long_sequence();
		test_width_extremes();
		test_random_text();
		settle();
		repeat (20) @(posedge clk);
		if (filtered_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, filtered_q.size());
			errors++;
		end
		$display("covered %0d input transactions (%0d bytes) in %0d strings", items_sent,
			bytes_seen, strings_sent);
		$display("colour, hyperlink, nF, utf-8, tab and overflow cases under several widths");
		if (errors == 0)
			$display("PASS ansi_escape_filter_core");
		else
			$display("FAIL ansi_escape_filter_core");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAIL ansi_escape_filter_core");
		$finish;
	end

endmodule

[ansi_escape_filter_core.f]
design/aef_pkg.sv
design/aef_queue.sv
design/aef_front.sv
design/aef_back.sv
design/ansi_escape_filter_core.sv
design/aef_checker.sv
test/tb_top.sv
